// File: rtl/core/npl_pkg.sv
// ----------------------------------------------------------------------------
// npl_pkg
// shared types and codes for the next lexicographic permutation engine
// ----------------------------------------------------------------------------
package npl_pkg;

    localparam int DIGIT_W = 4;

    // request operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // one result pushed from the sequencer into the output register
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               exhausted;
    } t_res;

endpackage

// File: rtl/core/npl_if.sv
// ----------------------------------------------------------------------------
// npl_req_if / npl_res_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface npl_req_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [3:0] digit_in;
    logic       first;

    modport source (output valid, output op, output digit_in, output first, input ready);
    modport sink   (input valid, input op, input digit_in, input first, output ready);
endinterface

interface npl_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_out;
    logic       last;
    logic       exhausted;

    modport source (output valid, output digit_out, output last, output exhausted,
                    input ready);
    modport sink   (input valid, input digit_out, input last, input exhausted,
                    output ready);
endinterface

// File: rtl/core/npl_ram.sv
// ----------------------------------------------------------------------------
// npl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module npl_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/npl_out.sv
// ----------------------------------------------------------------------------
// npl_out
// output register for results, frees itself as the consumer takes a result
// ----------------------------------------------------------------------------
module npl_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  npl_pkg::t_res i_res,
    output logic          o_free,
    npl_res_if.source     o_res
);

    logic                        r_valid;
    logic [npl_pkg::DIGIT_W-1:0] r_digit;
    logic                        r_last;
    logic                        r_exhausted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_digit     <= i_res.digit;
            r_last      <= i_res.last;
            r_exhausted <= i_res.exhausted;
        end
    end

    assign o_free          = !r_valid || o_res.ready;
    assign o_res.valid     = r_valid;
    assign o_res.digit_out = r_digit;
    assign o_res.last      = r_last;
    assign o_res.exhausted = r_exhausted;

`ifndef SYNTH
    // sequencer only pushes into a free register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid |-> o_free)
        else $error("result pushed into occupied output register");
`endif

endmodule

// File: rtl/core/npl_seq.sv
// ----------------------------------------------------------------------------
// npl_seq
// sequencer: loads digits and runs pivot scan, successor scan, swap,
// tail reversal and readout over the digit ram
// ----------------------------------------------------------------------------
module npl_seq #(
    parameter int MAX_DIGITS = 16,
    localparam int AW = $clog2(MAX_DIGITS),
    localparam int LW = $clog2(MAX_DIGITS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    npl_req_if.sink                     i_req,
    input  logic                        i_out_free,
    output npl_pkg::t_res               o_res,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [npl_pkg::DIGIT_W-1:0] o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [npl_pkg::DIGIT_W-1:0] i_rdata
);

    localparam int DW = npl_pkg::DIGIT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PV_RD = 4'd1;
    localparam logic [3:0] S_PV_WT = 4'd2;
    localparam logic [3:0] S_SC_RD = 4'd3;
    localparam logic [3:0] S_SC_WT = 4'd4;
    localparam logic [3:0] S_SW_P  = 4'd5;
    localparam logic [3:0] S_SW_S  = 4'd6;
    localparam logic [3:0] S_RV_RL = 4'd7;
    localparam logic [3:0] S_RV_RH = 4'd8;
    localparam logic [3:0] S_RV_WL = 4'd9;
    localparam logic [3:0] S_RV_WH = 4'd10;
    localparam logic [3:0] S_EM_RD = 4'd11;
    localparam logic [3:0] S_EM_WT = 4'd12;
    localparam logic [3:0] S_EXH   = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [LW-1:0] r_len,   n_len;
    logic [AW-1:0] r_idx,   n_idx;
    logic [AW-1:0] r_sidx,  n_sidx;
    logic [AW-1:0] r_lo,    n_lo;
    logic [AW-1:0] r_hi,    n_hi;
    logic [AW-1:0] r_k,     n_k;
    logic [DW-1:0] r_prev,  n_prev;
    logic [DW-1:0] r_pv,    n_pv;
    logic [DW-1:0] r_sv,    n_sv;
    logic [DW-1:0] r_tmp,   n_tmp;
    logic          r_have,  n_have;

    logic [LW-1:0] len_m1;
    logic [AW-1:0] last_idx;
    logic          accept;

    assign len_m1   = r_len - LW'(1);
    assign last_idx = len_m1[AW-1:0];
    assign i_req.ready = (r_state == S_IDLE);
    assign accept   = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_idx   = r_idx;
        n_sidx  = r_sidx;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_k     = r_k;
        n_prev  = r_prev;
        n_pv    = r_pv;
        n_sv    = r_sv;
        n_tmp   = r_tmp;
        n_have  = r_have;
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = '0;
        o_re    = 1'b0;
        o_raddr = '0;
        o_res   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.op == npl_pkg::OP_LOAD) begin
                        if (i_req.first) begin
                            o_we    = 1'b1;
                            o_waddr = '0;
                            o_wdata = i_req.digit_in;
                            n_len   = LW'(1);
                        end else if (r_len < LW'(MAX_DIGITS)) begin
                            o_we    = 1'b1;
                            o_waddr = r_len[AW-1:0];
                            o_wdata = i_req.digit_in;
                            n_len   = r_len + LW'(1);
                        end
                    end else if (r_len < LW'(2)) begin
                        n_state = S_EXH;
                    end else begin
                        n_idx   = last_idx;
                        n_have  = 1'b0;
                        n_state = S_PV_RD;
                    end
                end
            end
            S_PV_RD: begin
                o_re    = 1'b1;
                o_raddr = r_idx;
                n_state = S_PV_WT;
            end
            S_PV_WT: begin
                if (!r_have) begin
                    n_prev  = i_rdata;
                    n_have  = 1'b1;
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PV_RD;
                end else if (i_rdata < r_prev) begin
                    // pivot found at r_idx
                    n_pv    = i_rdata;
                    n_sidx  = last_idx;
                    n_state = S_SC_RD;
                end else if (r_idx == '0) begin
                    n_state = S_EXH;
                end else begin
                    n_prev  = i_rdata;
                    n_idx   = r_idx - AW'(1);
                    n_state = S_PV_RD;
                end
            end
            S_SC_RD: begin
                o_re    = 1'b1;
                o_raddr = r_sidx;
                n_state = S_SC_WT;
            end
            S_SC_WT: begin
                if (i_rdata > r_pv) begin
                    n_sv    = i_rdata;
                    n_state = S_SW_P;
                end else begin
                    n_sidx  = r_sidx - AW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_SW_P: begin
                o_we    = 1'b1;
                o_waddr = r_idx;
                o_wdata = r_sv;
                n_state = S_SW_S;
            end
            S_SW_S: begin
                o_we    = 1'b1;
                o_waddr = r_sidx;
                o_wdata = r_pv;
                n_lo    = r_idx + AW'(1);
                n_hi    = last_idx;
                n_k     = '0;
                if ((r_idx + AW'(1)) < last_idx) begin
                    n_state = S_RV_RL;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_RV_RL: begin
                o_re    = 1'b1;
                o_raddr = r_lo;
                n_state = S_RV_RH;
            end
            S_RV_RH: begin
                n_tmp   = i_rdata;
                o_re    = 1'b1;
                o_raddr = r_hi;
                n_state = S_RV_WL;
            end
            S_RV_WL: begin
                o_we    = 1'b1;
                o_waddr = r_lo;
                o_wdata = i_rdata;
                n_state = S_RV_WH;
            end
            S_RV_WH: begin
                o_we    = 1'b1;
                o_waddr = r_hi;
                o_wdata = r_tmp;
                n_lo    = r_lo + AW'(1);
                n_hi    = r_hi - AW'(1);
                n_k     = '0;
                if ((r_lo + AW'(1)) < (r_hi - AW'(1))) begin
                    n_state = S_RV_RL;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_EM_RD: begin
                o_re    = 1'b1;
                o_raddr = r_k;
                n_state = S_EM_WT;
            end
            S_EM_WT: begin
                if (i_out_free) begin
                    o_res.valid     = 1'b1;
                    o_res.digit     = i_rdata;
                    o_res.last      = (r_k == last_idx);
                    o_res.exhausted = 1'b0;
                    if (r_k == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + AW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            S_EXH: begin
                if (i_out_free) begin
                    o_res.valid     = 1'b1;
                    o_res.digit     = '0;
                    o_res.last      = 1'b1;
                    o_res.exhausted = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_sidx <= n_sidx;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_k    <= n_k;
        r_prev <= n_prev;
        r_pv   <= n_pv;
        r_sv   <= n_sv;
        r_tmp  <= n_tmp;
        r_have <= n_have;
    end

`ifndef SYNTH
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_DIGITS))
        else $error("digit count above capacity");

    // successor search never walks into the pivot or left of it
    a_scan_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_WT) |-> (r_sidx > r_idx))
        else $error("successor scan left the tail");
`endif

endmodule

// File: rtl/core/next_lexicographic_permutation.sv
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// digit sequence held in a ram, stepped to its lexicographic successor
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                         role
//  i_req    in   op, digit_in, first            load a digit or request advance
//  o_res    out  digit_out, last, exhausted     digits of the new permutation
//
//  a load request writes its digit straight to the ram
//  an advance runs the pivot scan, successor scan, swap, tail reversal and
//  readout of all n digits, paced by the single registered read port
//  an empty or one-digit sequence answers with one exhausted result; a
//  longer one with no ascent answers with it after a full pivot scan
//  reset clears the digit count and state; the ram contents are not cleared
//  output stalls hold the readout; a new request is taken while the final
//  result still waits in the output register
//
module next_lexicographic_permutation #(
    parameter int MAX_DIGITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    npl_req_if.sink   i_req,
    npl_res_if.source o_res
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int DW = npl_pkg::DIGIT_W;

    // digit ram port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    // result push from sequencer into output register
    npl_pkg::t_res res_push;
    logic          out_free;

    // sequencer: scans, swaps, reverses and reads out the digits
    npl_seq #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_out_free (out_free),
        .o_res      (res_push),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_re       (ram_re),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata)
    );

    // digit storage
    npl_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DIGITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register decouples readout from the consumer
    npl_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res_push),
        .o_free  (out_free),
        .o_res   (o_res)
    );

`ifndef SYNTH
    // read and write never hit the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("ram read and write collide on one entry");

    // an advance request keeps the block busy for at least the next cycle
    a_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.op == npl_pkg::OP_ADVANCE))
        |=> !i_req.ready)
        else $error("request taken right after an advance");

    // an exhausted result is a lone zero digit marked last
    a_exh_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.exhausted) |-> (o_res.last && (o_res.digit_out == '0)))
        else $error("malformed exhausted result");
`endif

endmodule
